FILE: rtl/core/s2cd_pkg.sv
// ----------------------------------------------------------------------------
// s2cd_pkg
// Constants and lookup tables for the seconds-to-calendar-date pipeline.
// ----------------------------------------------------------------------------
package s2cd_pkg;

	localparam int NUM_STAGES = 7;

	localparam logic [31:0] FIVE_DAYS_SEC = 32'd432000;
	localparam logic [16:0] OFFSET_RESET  = 17'd32400;
	localparam logic [11:0] BASE_YEAR     = 12'd1980;

	localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
	localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
	localparam logic [5:0]  SECS_PER_MIN  = 6'd60;
	localparam logic [10:0] QUAD_DAYS     = 11'(366 + (3 * 365));

	// 86400 = 128 * 675: drop seven bits, then divide by 675
	localparam int DAY_SHIFT_IN = 7;
	localparam int DAY_DIVISOR  = 675;
	localparam int DAY_SHIFT    = 35;
	localparam logic [25:0] DAY_RECIP =
		26'(((64'd1 << DAY_SHIFT) + 64'(DAY_DIVISOR - 1)) / 64'(DAY_DIVISOR));

	localparam int QUAD_SHIFT = 27;
	localparam logic [16:0] QUAD_RECIP =
		17'(((64'd1 << QUAD_SHIFT) + 64'd1460) / 64'd1461);

	localparam int HOUR_SHIFT = 29;
	localparam logic [17:0] HOUR_RECIP =
		18'(((64'd1 << HOUR_SHIFT) + 64'd3599) / 64'd3600);

	localparam int MIN_SHIFT = 18;
	localparam logic [12:0] MIN_RECIP =
		13'(((64'd1 << MIN_SHIFT) + 64'd59) / 64'd60);

	// first day of each year in a four-year group
	localparam logic [10:0] YEAR_START [4] = '{11'd0, 11'd366, 11'd731, 11'd1096};

	// first day of each month, row 0 leap year, row 1 common year
	localparam logic [8:0] MONTH_START [2][12] = '{
		'{9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152,
		  9'd182, 9'd213, 9'd244, 9'd274, 9'd305, 9'd335},
		'{9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
		  9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334}
	};

	localparam logic [3:0] DEFAULT_MONTH = 4'd1;
	localparam logic [4:0] DEFAULT_DAY   = 5'd6;

endpackage

FILE: rtl/core/seconds_to_calendar_date_core.sv
// ----------------------------------------------------------------------------
// seconds_to_calendar_date_core
// Converts a seconds count since 1980-01-06 into local calendar date and time.
// ----------------------------------------------------------------------------
// channel | direction | handshake            | payload
// in      | input     | in_valid / in_ready  | epoch_seconds
// out     | output    | out_valid / out_ready| year, month, day_of_month,
//         |           |                      | hour, minute, second
// cfg     | input     | cfg_valid / cfg_ready| local_offset_seconds
//
// Seven register stages, constant-reciprocal divides in stages two, three, four
// and six; one beat is taken per cycle when out is not stalled.
// Each stage holds its beat only while the stage after it is full and stalled,
// so bubbles collapse; in_ready drops only once all seven stages hold a beat
// and out is stalled.
// Reset clears all stage valid bits and loads the nine-hour offset.
// cfg is always ready; the offset applies to beats taken after the write.
// ----------------------------------------------------------------------------
module seconds_to_calendar_date_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] epoch_seconds,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [11:0] year,
	output logic [3:0]  month,
	output logic [4:0]  day_of_month,
	output logic [4:0]  hour,
	output logic [5:0]  minute,
	output logic [5:0]  second,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic signed [16:0] local_offset_seconds
);
	import s2cd_pkg::*;

	logic [16:0]           offset_q;
	logic [NUM_STAGES:1]   stage_vld_q;
	logic [NUM_STAGES:1]   stage_adv;

	// stage payload registers
	logic [31:0] secs_s1, secs_s2;
	logic        zero_s1, zero_s2, zero_s3, zero_s4, zero_s5, zero_s6;
	logic [15:0] days_s2, days_s3;
	logic [16:0] tod_s3, tod_s4;
	logic [5:0]  quad_s3, quad_s4, quad_s5;
	logic [10:0] rem_s4;
	logic [4:0]  hour_s4, hour_s5, hour_s6, hour_s7;
	logic [11:0] sh_s5, sh_s6;
	logic [1:0]  yi_s5;
	logic [8:0]  dy_s5;
	logic [5:0]  minute_s6, minute_s7;
	logic [11:0] year_s6, year_s7;
	logic [3:0]  month_s6, month_s7;
	logic [4:0]  day_s6, day_s7;
	logic [5:0]  second_s7;

	// stage logic
	logic [31:0] in_sum;
	logic [50:0] day_prod;
	logic [32:0] day_secs, tod_full, quad_prod;
	logic [16:0] quad_days, rem_full;
	logic [34:0] hour_prod;
	logic [16:0] hour_secs, sh_full;
	logic [1:0]  yi_nxt;
	logic [10:0] dy_full;
	logic [24:0] min_prod;
	logic        month_row;
	logic [3:0]  mi_nxt;
	logic [8:0]  day_full;
	logic [11:0] min_secs, sec_full;

	assign cfg_ready = 1'b1;
	assign in_ready  = stage_adv[1];
	assign out_valid = stage_vld_q[NUM_STAGES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= OFFSET_RESET;
		end else if (cfg_valid && cfg_ready) begin
			offset_q <= local_offset_seconds;
		end
	end

	// a stage moves when it is empty or the next one moves
	always_comb begin
		stage_adv[NUM_STAGES] = !stage_vld_q[NUM_STAGES] || out_ready;
		for (int i = NUM_STAGES - 1; i >= 1; i--) begin
			stage_adv[i] = !stage_vld_q[i] || stage_adv[i + 1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_vld_q <= '0;
		end else begin
			if (stage_adv[1]) begin
				stage_vld_q[1] <= in_valid;
			end
			for (int i = 2; i <= NUM_STAGES; i++) begin
				if (stage_adv[i]) begin
					stage_vld_q[i] <= stage_vld_q[i - 1];
				end
			end
		end
	end

	// stage 1: wrap-around sum of input, five days and offset
	assign in_sum = epoch_seconds + FIVE_DAYS_SEC + {{15{offset_q[16]}}, offset_q};

	always_ff @(posedge clk) begin
		if (stage_adv[1]) begin
			secs_s1 <= in_sum;
			zero_s1 <= (epoch_seconds == 32'd0);
		end
	end

	// stage 2: whole days
	assign day_prod = 51'(secs_s1[31:DAY_SHIFT_IN]) * 51'(DAY_RECIP);

	always_ff @(posedge clk) begin
		if (stage_adv[2]) begin
			secs_s2 <= secs_s1;
			zero_s2 <= zero_s1;
			days_s2 <= day_prod[DAY_SHIFT +: 16];
		end
	end

	// stage 3: time of day and four-year group
	assign day_secs  = 33'(days_s2) * 33'(SECS_PER_DAY);
	assign tod_full  = {1'b0, secs_s2} - day_secs;
	assign quad_prod = 33'(days_s2) * 33'(QUAD_RECIP);

	always_ff @(posedge clk) begin
		if (stage_adv[3]) begin
			zero_s3 <= zero_s2;
			days_s3 <= days_s2;
			tod_s3  <= tod_full[16:0];
			quad_s3 <= quad_prod[QUAD_SHIFT +: 6];
		end
	end

	// stage 4: day within group, hour
	assign quad_days = 17'(quad_s3) * 17'(QUAD_DAYS);
	assign rem_full  = {1'b0, days_s3} - quad_days;
	assign hour_prod = 35'(tod_s3) * 35'(HOUR_RECIP);

	always_ff @(posedge clk) begin
		if (stage_adv[4]) begin
			zero_s4 <= zero_s3;
			tod_s4  <= tod_s3;
			quad_s4 <= quad_s3;
			rem_s4  <= rem_full[10:0];
			hour_s4 <= hour_prod[HOUR_SHIFT +: 5];
		end
	end

	// stage 5: seconds within hour, year within group
	assign hour_secs = 17'(hour_s4) * 17'(SECS_PER_HOUR);
	assign sh_full   = tod_s4 - hour_secs;
	assign yi_nxt    = 2'(rem_s4 >= YEAR_START[1]) + 2'(rem_s4 >= YEAR_START[2])
		+ 2'(rem_s4 >= YEAR_START[3]);
	assign dy_full   = rem_s4 - YEAR_START[yi_nxt];

	always_ff @(posedge clk) begin
		if (stage_adv[5]) begin
			zero_s5 <= zero_s4;
			quad_s5 <= quad_s4;
			hour_s5 <= hour_s4;
			sh_s5   <= sh_full[11:0];
			yi_s5   <= yi_nxt;
			dy_s5   <= dy_full[8:0];
		end
	end

	// stage 6: minute, month and day, year
	assign min_prod  = 25'(sh_s5) * 25'(MIN_RECIP);
	assign month_row = (yi_s5 != 2'd0);

	always_comb begin
		mi_nxt = '0;
		for (int k = 1; k < 12; k++) begin
			mi_nxt = mi_nxt + 4'(dy_s5 >= MONTH_START[month_row][k]);
		end
	end

	assign day_full = dy_s5 - MONTH_START[month_row][mi_nxt] + 9'd1;

	always_ff @(posedge clk) begin
		if (stage_adv[6]) begin
			zero_s6   <= zero_s5;
			hour_s6   <= hour_s5;
			sh_s6     <= sh_s5;
			minute_s6 <= min_prod[MIN_SHIFT +: 6];
			month_s6  <= mi_nxt + 4'd1;
			day_s6    <= day_full[4:0];
			year_s6   <= BASE_YEAR + 12'({quad_s5, yi_s5});
		end
	end

	// stage 7: second, zero input forces the fixed date
	assign min_secs = 12'(minute_s6) * 12'(SECS_PER_MIN);
	assign sec_full = sh_s6 - min_secs;

	always_ff @(posedge clk) begin
		if (stage_adv[7]) begin
			if (zero_s6) begin
				year_s7   <= BASE_YEAR;
				month_s7  <= DEFAULT_MONTH;
				day_s7    <= DEFAULT_DAY;
				hour_s7   <= '0;
				minute_s7 <= '0;
				second_s7 <= '0;
			end else begin
				year_s7   <= year_s6;
				month_s7  <= month_s6;
				day_s7    <= day_s6;
				hour_s7   <= hour_s6;
				minute_s7 <= minute_s6;
				second_s7 <= sec_full[5:0];
			end
		end
	end

	assign year         = year_s7;
	assign month        = month_s7;
	assign day_of_month = day_s7;
	assign hour         = hour_s7;
	assign minute       = minute_s7;
	assign second       = second_s7;

	// a free output slot lets every stage move, so input is open
	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(!out_valid || out_ready) |-> in_ready)
		else $error("input stalled while pipeline can drain");

	a_time_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (hour < 5'd24) && (minute < 6'd60) && (second < 6'd60))
		else $error("time of day out of range");

	a_date_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (month >= 4'd1) && (month <= 4'd12)
			&& (day_of_month >= 5'd1) && (year >= BASE_YEAR) && (year <= 12'd2119))
		else $error("calendar date out of range");

	a_offset_written: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |=> (offset_q == $past(local_offset_seconds)))
		else $error("offset write lost");

endmodule

FILE: test/tb_seconds_to_calendar_date_core.sv
// ----------------------------------------------------------------------------
// tb_seconds_to_calendar_date_core
// Self-checking bench for the seconds-to-calendar-date pipeline. A directed
// table covers the zero input, wrap of the sum, month, year and leap-day
// edges and the year 2100. Random beats then run under several offset
// settings, with random stalls on both channels and one long output stall.
// Each result is compared field by field to a table row or a local date calculation.
// ----------------------------------------------------------------------------
module tb_seconds_to_calendar_date_core;
	import s2cd_pkg::*;

	localparam int NUM_PHASES      = 8;
	localparam int ITEMS_PER_PHASE = 120;
	localparam int DIRECTED_ROWS   = 23;
	localparam int LONG_HOLD       = 80;
	localparam int STUCK_LIMIT     = 2000;
	localparam int LONG_HOLD_AT    = 200;

	localparam int unsigned DAY_SECS  = 86400;
	localparam int unsigned QUAD_DAYS_TB = 1461;
	localparam int unsigned DAYS_IN_MONTH [12] =
		'{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

	typedef struct packed {
		logic [11:0] yr;
		logic [3:0]  mon;
		logic [4:0]  mday;
		logic [4:0]  hr;
		logic [5:0]  mins;
		logic [5:0]  sec;
	} date_t;

	typedef struct packed {
		logic        known;
		logic [31:0] secs;
		date_t       want;
	} vector_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [31:0] epoch_seconds;
	logic        out_valid;
	logic        out_ready;
	logic [11:0] year;
	logic [3:0]  month;
	logic [4:0]  day_of_month;
	logic [4:0]  hour;
	logic [5:0]  minute;
	logic [5:0]  second;
	logic        cfg_valid;
	logic        cfg_ready;
	logic signed [16:0] local_offset_seconds;

	date_t              pending_dates [$];
	logic signed [16:0] offset_now;
	vector_t            directed_tbl [DIRECTED_ROWS];
	logic signed [16:0] phase_offsets [NUM_PHASES];
	date_t              want_d;
	date_t              got_d;
	int                 idle_pct;
	bit                 quiet;
	int                 errors;
	int                 results_seen;
	int                 stuck_cycles;

	seconds_to_calendar_date_core u_dut (.*);

	// epoch value that lands on a given day and second after 1980-01-01,
	// assuming the reset offset
	function automatic logic [31:0] at_day(input int unsigned d, input int unsigned s);
		longint unsigned t;
		t = longint'(d) * DAY_SECS + s - 64'(FIVE_DAYS_SEC) - 64'(OFFSET_RESET);
		return t[31:0];
	endfunction

	function automatic date_t calendar_of(input logic [31:0] secs,
		input logic signed [16:0] offs);
		date_t       d;
		logic [31:0] total;
		int unsigned days;
		int unsigned year_len;
		int unsigned mon_len;
		int          k;
		bit          leap;
		if (secs == '0) begin
			return '{12'd1980, 4'd1, 5'd6, 5'd0, 6'd0, 6'd0};
		end
		total = secs + 32'd432000 + {{15{offs[16]}}, offs};
		d.sec = 6'(total % 60);
		total = total / 60;
		d.mins = 6'(total % 60);
		total = total / 60;
		d.hr = 5'(total % 24);
		days = total / 24;
		d.yr = 12'(1980 + 4 * (days / QUAD_DAYS_TB));
		days = days % QUAD_DAYS_TB;
		// the first year of each group is the leap year
		leap = 1'b1;
		year_len = 366;
		for (k = 0; k < 3 && days >= year_len; k++) begin
			days -= year_len;
			d.yr++;
			leap = 1'b0;
			year_len = 365;
		end
		d.mon = 4'd1;
		for (k = 0; k < 11; k++) begin
			mon_len = DAYS_IN_MONTH[k] + ((k == 1 && leap) ? 1 : 0);
			if (days < mon_len) break;
			days -= mon_len;
			d.mon++;
		end
		d.mday = 5'(days + 1);
		return d;
	endfunction

	task automatic offer_secs(input logic [31:0] secs, input date_t want);
		if (!quiet && $urandom_range(1, 100) <= idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		in_valid <= 1'b1;
		epoch_seconds <= secs;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		pending_dates.push_back(want);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_dates.size() != 0) @(posedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		logic [31:0] secs;
		int          ph;
		int          n;
		arst_n = 1'b0;
		in_valid = 1'b0;
		epoch_seconds = '0;
		cfg_valid = 1'b0;
		local_offset_seconds = '0;
		offset_now = OFFSET_RESET;
		idle_pct = 25;
		quiet = 1'b0;

		directed_tbl = '{
			'{1'b1, 32'd0,         '{12'd1980, 4'd1, 5'd6, 5'd0, 6'd0,  6'd0}},
			'{1'b1, 32'd1,         '{12'd1980, 4'd1, 5'd6, 5'd9, 6'd0,  6'd1}},
			'{1'b1, 32'hFFFF_FFFF, '{12'd1980, 4'd1, 5'd6, 5'd8, 6'd59, 6'd59}},
			// sum wraps to exactly zero
			'{1'b1, at_day(0, 0),  '{12'd1980, 4'd1, 5'd1, 5'd0, 6'd0,  6'd0}},
			'{1'b0, at_day(5, 0), '0},
			'{1'b0, at_day(30, 86399), '0},
			'{1'b0, at_day(31, 0), '0},
			'{1'b0, at_day(59, 0), '0},
			'{1'b0, at_day(60, 0), '0},
			'{1'b0, at_day(365, 86399), '0},
			'{1'b0, at_day(366, 0), '0},
			'{1'b0, at_day(366 + 58, 86399), '0},
			'{1'b0, at_day(366 + 59, 0), '0},
			'{1'b0, at_day(1095, 86399), '0},
			'{1'b0, at_day(1460, 86399), '0},
			'{1'b0, at_day(1461, 0), '0},
			// 2100 still counts as a leap year
			'{1'b0, at_day(43888, 86399), '0},
			'{1'b0, at_day(43889, 0), '0},
			'{1'b0, at_day(43890, 0), '0},
			'{1'b0, 32'hFFFF_FFFF - 32'd464400, '0},
			'{1'b0, 32'h8000_0000, '0},
			'{1'b0, 32'h7FFF_FFFF, '0},
			'{1'b0, 32'h5555_5555, '0}
		};
		phase_offsets = '{17'h10000, -17'sd50400, 17'sd50400, 17'h0FFFF, 17'sd0,
			17'($urandom_range(0, 100800) - 32'd50400), 17'($urandom()),
			OFFSET_RESET};

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_tbl[i]) begin
			offer_secs(directed_tbl[i].secs, directed_tbl[i].known ? directed_tbl[i].want
				: calendar_of(directed_tbl[i].secs, offset_now));
		end

		for (ph = 0; ph < NUM_PHASES; ph++) begin
			// offset only changes with the pipeline empty
			drain();
			cfg_valid <= 1'b1;
			local_offset_seconds <= phase_offsets[ph];
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
			cfg_valid <= 1'b0;
			offset_now = phase_offsets[ph];
			idle_pct = (ph % 3 == 0) ? 0 : ((ph % 3 == 1) ? 15 : 40);
			quiet = (ph == NUM_PHASES - 1);

			for (n = 0; n < ITEMS_PER_PHASE; n++) begin
				case ($urandom_range(0, 15))
					0: secs = '0;
					1: secs = 32'hFFFF_FFFF - 32'($urandom_range(0, 600000));
					2: secs = 32'($urandom_range(1, 200000));
					3, 4: secs = at_day($urandom_range(0, 49709),
						$urandom_range(0, 1) ? 86399 : 0);
					default: secs = $urandom();
				endcase
				offer_secs(secs, calendar_of(secs, offset_now));
			end
		end

		drain();
		repeat (2 * NUM_STAGES) @(posedge clk);
		if (errors == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	// output side: random stalls plus one long hold that backs up the pipe
	initial begin
		int hold;
		bit held_long;
		out_ready = 1'b0;
		held_long = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (!held_long && results_seen >= LONG_HOLD_AT) begin
				held_long = 1'b1;
				out_ready <= 1'b0;
				hold = 0;
				while (hold < LONG_HOLD) begin
					@(posedge clk);
					hold++;
				end
			end else if (!quiet && $urandom_range(1, 100) <= idle_pct) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 7)) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				stuck_cycles = 0;
			else
				stuck_cycles++;

			if (out_valid && out_ready) begin
				results_seen++;
				if (pending_dates.size() == 0) begin
					$error("result beat with no pending date");
					errors++;
				end else begin
					want_d = pending_dates.pop_front();
					got_d = '{year, month, day_of_month, hour, minute, second};
					if (got_d.yr !== want_d.yr) begin
						$error("year: expected %0d, got %0d", want_d.yr, got_d.yr);
						errors++;
					end
					if (got_d.mon !== want_d.mon) begin
						$error("month: expected %0d, got %0d", want_d.mon, got_d.mon);
						errors++;
					end
					if (got_d.mday !== want_d.mday) begin
						$error("day_of_month: expected %0d, got %0d", want_d.mday, got_d.mday);
						errors++;
					end
					if (got_d.hr !== want_d.hr) begin
						$error("hour: expected %0d, got %0d", want_d.hr, got_d.hr);
						errors++;
					end
					if (got_d.mins !== want_d.mins) begin
						$error("minute: expected %0d, got %0d", want_d.mins, got_d.mins);
						errors++;
					end
					if (got_d.sec !== want_d.sec) begin
						$error("second: expected %0d, got %0d", want_d.sec, got_d.sec);
						errors++;
					end
				end
			end
		end
	end

	initial begin
		errors = 0;
		results_seen = 0;
		stuck_cycles = 0;
		wait (arst_n === 1'b1);
		while (stuck_cycles < STUCK_LIMIT) @(posedge clk);
		$display("end of test: mismatches");
		$finish;
	end

endmodule
